>>> rtl/assert_macros.svh
// Assertion macros shared by the codec RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/b64c_pkg.sv
// Types, constants and alphabet functions of the base64 codec.
// No dependencies; used by every codec module.
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam int         JOBQ_DEPTH = 2;
    localparam int         JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int         JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_ENC = 2'd0,
        JOB_DEC = 2'd1,
        JOB_ERR = 2'd2
    } t_job_kind;

    // One group handed from the front to the back.
    typedef struct packed {
        t_job_kind   kind;
        logic [23:0] bits;  // group bits, left aligned
        logic [1:0]  cnt;   // bytes in the group
        logic        last;
    } t_job;

    // Map a 6-bit value to its base64 character.
    function automatic logic [7:0] b64_enc_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'h41 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'h61 + {2'b00, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            c = 8'h30 + {2'b00, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Map a character to {valid, value}; valid is 0 outside the alphabet.
    function automatic logic [6:0] b64_dec_char(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

>>> rtl/base64_codec_strict.sv
// Top level of the streaming base64 codec (standard alphabet, strict decode).
// Depends on b64c_pkg, b64c_front, b64c_jobq and b64c_back.
//
// Usage:
//   Input channel: a word is one byte plus a last flag, taken at a clock edge
//   with push high and full low. Result channel: while empty is low the
//   oldest result word is on o_out_value/o_out_last/o_out_error; pop takes it.
//   Configuration: i_cfg_we writes i_cfg_wdata into the direction register
//   (0 encode, 1 decode) and clears any partial group. Write it only idle.
//   Encode: every third byte, or a byte with last, yields four characters,
//   padded with '=' for a short final group; out_last marks the fourth of the final group.
//   Decode: every fourth character yields one to three bytes. A malformed
//   stream yields a single error word (value 0, last 1, error 1); words up to
//   its last flag are then dropped, and bytes already sent must be discarded.
//   A group's job enters the queue with the word completing it; its first result
//   then shows through the output register. One word in per cycle while full is
//   low, one result out per cycle while pop is high; the result port caps the
//   encode rate, as three bytes give four results. A two-entry job queue between
//   front and back fills when pop stalls and the output register holds; full rises.
//   Reset: synchronous active low; clears direction to encode and all control state.
module base64_codec_strict import b64c_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_value,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_value,
    output logic       o_out_last,
    output logic       o_out_error
);

    logic r_direction;

    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_job front_job;
    t_job head_job;

    // direction register; a write also flushes the front's stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_wdata;
        end
    end

    // front: accept and classify words, build group jobs
    b64c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_direction (r_direction),
        .i_clear     (i_cfg_we),
        .i_push      (push),
        .i_value     (i_in_value),
        .i_last      (i_in_last),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_job_push  (q_push),
        .o_job       (front_job)
    );

    // decouple the two sides so each can stall on its own
    b64c_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    // back: expand each job into result words through the output register
    b64c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_value   (o_out_value),
        .o_last    (o_out_last),
        .o_error   (o_out_error)
    );

endmodule

>>> rtl/b64c_front.sv
// Front end of the base64 codec: accepts words, gathers groups, checks decode input.
// Depends on b64c_pkg; feeds b64c_jobq with one job per finished group or error.
module b64c_front import b64c_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_direction,
    input  logic       i_clear,
    input  logic       i_push,
    input  logic [7:0] i_value,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_job_push,
    output t_job       o_job
);

    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_pos, n_pos;
    logic [1:0]  r_pad, n_pad;
    logic        r_bad, n_bad;

    logic        accept;
    logic [23:0] enc_bits;
    logic [1:0]  enc_pos;
    logic [6:0]  dec;
    logic        is_pad;
    logic        err;
    logic [1:0]  pad_new;
    logic [5:0]  q;
    logic [23:0] dec_bits;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        n_bits     = r_bits;
        n_pos      = r_pos;
        n_pad      = r_pad;
        n_bad      = r_bad;
        o_job_push = 1'b0;
        o_job      = '{kind: JOB_ENC, bits: 24'd0, cnt: 2'd0, last: i_last};
        enc_bits   = {r_bits[15:0], i_value};
        enc_pos    = r_pos + 2'd1;
        dec        = b64_dec_char(i_value);
        is_pad     = (i_value == PAD_CHAR);
        err        = 1'b0;
        pad_new    = r_pad;
        q          = is_pad ? 6'd0 : dec[5:0];
        dec_bits   = {r_bits[17:0], q};

        if (accept) begin
            if (!i_direction) begin
                if (enc_pos == 2'd3 || i_last) begin
                    o_job_push = 1'b1;
                    o_job.kind = JOB_ENC;
                    o_job.cnt  = enc_pos;
                    unique case (enc_pos)
                        2'd1:    o_job.bits = {enc_bits[7:0], 16'd0};
                        2'd2:    o_job.bits = {enc_bits[15:0], 8'd0};
                        default: o_job.bits = enc_bits;
                    endcase
                    n_bits = 24'd0;
                    n_pos  = 2'd0;
                end else begin
                    n_bits = enc_bits;
                    n_pos  = enc_pos;
                end
            end else if (r_bad) begin
                // drop the rest of a rejected stream
                if (i_last) begin
                    n_bits = 24'd0;
                    n_pos  = 2'd0;
                    n_pad  = 2'd0;
                    n_bad  = 1'b0;
                end
            end else begin
                if (r_pad != 2'd0 && r_pos == 2'd0) begin
                    err = 1'b1;
                end else if (is_pad) begin
                    if (r_pos < 2'd2) begin
                        err = 1'b1;
                    end else begin
                        pad_new = r_pad + 2'd1;
                    end
                end else if (r_pad != 2'd0) begin
                    err = 1'b1;
                end else if (!dec[6]) begin
                    err = 1'b1;
                end
                if (i_last && r_pos != 2'd3) begin
                    err = 1'b1;
                end

                if (err) begin
                    o_job_push = 1'b1;
                    o_job.kind = JOB_ERR;
                    o_job.last = 1'b1;
                    n_bits     = 24'd0;
                    n_pos      = 2'd0;
                    n_pad      = 2'd0;
                    n_bad      = !i_last;
                end else if (r_pos != 2'd3) begin
                    n_bits = dec_bits;
                    n_pos  = r_pos + 2'd1;
                    n_pad  = pad_new;
                end else begin
                    o_job_push = 1'b1;
                    o_job.kind = JOB_DEC;
                    o_job.bits = dec_bits;
                    o_job.cnt  = 2'd3 - pad_new;
                    n_bits     = 24'd0;
                    n_pos      = 2'd0;
                    n_pad      = i_last ? 2'd0 : pad_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bits <= 24'd0;
            r_pos  <= 2'd0;
            r_pad  <= 2'd0;
            r_bad  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_pos  <= n_pos;
            r_pad  <= n_pad;
            r_bad  <= n_bad;
        end
    end

endmodule

>>> rtl/b64c_jobq.sv
// Short job queue between the codec front end and back end.
// Depends on b64c_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64c_jobq import b64c_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] r_wp;
    logic [JOBQ_AW-1:0] r_rp;
    logic [JOBQ_CW-1:0] r_count, n_count;

    assign o_full  = (r_count == JOBQ_CW'(JOBQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && r_count == JOBQ_CW'(JOBQ_DEPTH))
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && r_count == '0)
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

>>> rtl/b64c_back.sv
// Back end of the base64 codec: expands one job into result words.
// Depends on b64c_pkg and assert_macros.svh; reads the head of b64c_jobq.
`include "assert_macros.svh"
module b64c_back import b64c_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_value,
    output logic       o_last,
    output logic       o_error
);

    logic [1:0] r_k;
    logic       r_valid;
    logic [7:0] r_value;
    logic       r_last;
    logic       r_error;

    logic       ld;
    logic [1:0] final_k;
    logic       is_final;
    logic [7:0] w_value;
    logic       w_error;

    assign ld = i_q_valid && (!r_valid || i_pop);

    always_comb begin
        final_k = 2'd0;
        w_value = 8'd0;
        w_error = 1'b0;
        unique case (i_job.kind)
            JOB_ENC: begin
                final_k = 2'd3;
                unique case (r_k)
                    2'd0: w_value = b64_enc_char(i_job.bits[23:18]);
                    2'd1: w_value = b64_enc_char(i_job.bits[17:12]);
                    2'd2: w_value = (i_job.cnt > 2'd1) ?
                                    b64_enc_char(i_job.bits[11:6]) : PAD_CHAR;
                    default: w_value = (i_job.cnt > 2'd2) ?
                                       b64_enc_char(i_job.bits[5:0]) : PAD_CHAR;
                endcase
            end
            JOB_DEC: begin
                final_k = i_job.cnt - 2'd1;
                unique case (r_k)
                    2'd0:    w_value = i_job.bits[23:16];
                    2'd1:    w_value = i_job.bits[15:8];
                    default: w_value = i_job.bits[7:0];
                endcase
            end
            JOB_ERR: begin
                w_error = 1'b1;
            end
            default: begin
                w_error = 1'b1;
            end
        endcase
        is_final = (r_k == final_k);
    end

    assign o_q_pop = ld && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 2'd0;
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= 1'b1;
            r_k     <= is_final ? 2'd0 : r_k + 2'd1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // hold the word until taken
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_value <= w_value;
            r_last  <= i_job.last && is_final;
            r_error <= w_error;
        end
    end

    assign o_empty = !r_valid;
    assign o_value = r_value;
    assign o_last  = r_last;
    assign o_error = r_error;

    `ASSERT_IMPLY(a_k_has_job, i_clk, i_rst_n, r_k != 2'd0, i_q_valid)
    `ASSERT_IMPLY(a_k_in_range, i_clk, i_rst_n, i_q_valid, r_k <= final_k)
    `ASSERT_IMPLY(a_err_word, i_clk, i_rst_n, r_valid && r_error, r_last && r_value == 8'd0)

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the streaming base64 codec (base64_codec_strict).
// Depends on b64c_pkg for the pad character; predicts every result word itself
// and checks the result port word by word against that prediction.
module tb;
    import b64c_pkg::*;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;
    localparam int   HOLD_LEN   = 150;   // long output stall, in cycles
    localparam int   SETTLE     = 8;     // lets the job queue and output register settle
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       error;
    } t_code_word;

    // Ways to damage an otherwise well-formed encoded stream.
    typedef enum int {
        FLAW_BYTE,
        FLAW_SHORT,
        FLAW_TAIL,
        FLAW_PAD
    } t_flaw;

    // DUT inputs, all known from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] i_in_value  = 8'h00;
    logic       i_in_last   = 1'b0;
    logic       pop         = 1'b0;

    logic       full;
    logic       empty;
    logic [7:0] o_out_value;
    logic       o_out_last;
    logic       o_out_error;

    // Shared control between the test tasks and the result side.
    logic idle_on   = 1'b1;   // random gaps on both sides
    logic hold_req  = 1'b0;   // ask the result side for one long stall
    logic hold_busy = 1'b0;   // result side is in that stall

    // Expected result words, oldest first.
    t_code_word awaited_words[$];
    logic [7:0] stream_buf[$];

    // Codec state as predicted by the testbench.
    logic        cur_dir;
    logic [23:0] grp_bits;
    logic [1:0]  grp_pos;
    logic [1:0]  pad_cnt;
    logic        bad_seen;
    int          char_code [0:255];

    int fail_count  = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int error_words = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    base64_codec_strict dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_value  (i_in_value),
        .i_in_last   (i_in_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Map a 6-bit value to its character in the standard alphabet.
    function automatic logic [7:0] sextet_char(input logic [5:0] idx);
        return B64_ALPHABET[8*(63 - int'(idx)) +: 8];
    endfunction

    function automatic void await_word(input logic [7:0] v, input logic l, input logic e);
        t_code_word w;
        w.value = v;
        w.last  = l;
        w.error = e;
        awaited_words.push_back(w);
    endfunction

    function automatic void clear_stream();
        grp_bits = '0;
        grp_pos  = '0;
        pad_cnt  = '0;
        bad_seen = 1'b0;
    endfunction

    // Advance the predicted codec by one accepted word and queue what it emits.
    function automatic void run_codec(input logic [7:0] v, input logic l);
        logic [23:0] w;
        logic        bad;
        int          q;
        int          n_out;
        if (cur_dir == DIR_ENCODE) begin
            grp_bits = {grp_bits[15:0], v};
            grp_pos  = grp_pos + 2'd1;
            // Flush on a full group or on the last byte; short groups get '='.
            if (grp_pos == 2'd3 || l) begin
                w = grp_bits << (8 * (3 - int'(grp_pos)));
                await_word(sextet_char(w[23:18]), 1'b0, 1'b0);
                await_word(sextet_char(w[17:12]), 1'b0, 1'b0);
                await_word(grp_pos > 2'd1 ? sextet_char(w[11:6]) : PAD_CHAR, 1'b0, 1'b0);
                await_word(grp_pos > 2'd2 ? sextet_char(w[5:0]) : PAD_CHAR, l, 1'b0);
                grp_bits = '0;
                grp_pos  = '0;
            end
        end else if (bad_seen) begin
            // Drop the rest of a rejected stream; its last word rearms.
            if (l)
                clear_stream();
        end else begin
            q   = 0;
            bad = 1'b0;
            if (pad_cnt != 2'd0 && grp_pos == 2'd0) begin
                bad = 1'b1;                       // anything after a padded group
            end else if (v == PAD_CHAR) begin
                if (grp_pos < 2'd2)
                    bad = 1'b1;                   // '=' too early in the group
                else
                    pad_cnt = pad_cnt + 2'd1;
            end else if (pad_cnt != 2'd0) begin
                bad = 1'b1;                       // data after '='
            end else begin
                q   = char_code[v];
                bad = (q < 0);                    // outside the alphabet
            end
            if (!bad && l && grp_pos != 2'd3)
                bad = 1'b1;                       // length not a multiple of four
            if (bad) begin
                await_word(8'h00, 1'b1, 1'b1);
                clear_stream();
                bad_seen = !l;
            end else begin
                grp_bits = {grp_bits[17:0], q[5:0]};
                if (grp_pos != 2'd3) begin
                    grp_pos = grp_pos + 2'd1;
                end else begin
                    n_out = 3 - int'(pad_cnt);
                    for (int k = 0; k < n_out; k++)
                        await_word(grp_bits[23-8*k -: 8], l && (k == n_out - 1), 1'b0);
                    grp_bits = '0;
                    grp_pos  = '0;
                    if (l)
                        pad_cnt = '0;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each popped word, then pick pop for the next cycle
    // ------------------------------------------------------------------

    task automatic check_word();
        t_code_word want;
        words_seen++;
        if (awaited_words.size() == 0) begin
            $display("%0t: unexpected word: value %h last %b error %b",
                     $time, o_out_value, o_out_last, o_out_error);
            fail_count++;
        end else begin
            want = awaited_words.pop_front();
            if (want.error)
                error_words++;
            if (o_out_value !== want.value) begin
                $display("%0t: out_value expected %h actual %h", $time, want.value, o_out_value);
                fail_count++;
            end
            if (o_out_last !== want.last) begin
                $display("%0t: out_last expected %b actual %b", $time, want.last, o_out_last);
                fail_count++;
            end
            if (o_out_error !== want.error) begin
                $display("%0t: out_error expected %b actual %b", $time, want.error, o_out_error);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin : result_side
        logic pop_next;
        if (i_rst_n && pop && !empty)
            check_word();
        pop_next = 1'b1;
        if (hold_left > 0) begin
            // Hold off for the long stall; the codec must back up into full.
            hold_left--;
            pop_next = 1'b0;
        end else if (hold_req) begin
            hold_left = HOLD_LEN - 1;
            pop_next  = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pop_next = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            // Start a stall burst; stall_left sets its length.
            stall_left = $urandom_range(0, 6);
            pop_next   = 1'b0;
        end
        hold_busy <= (hold_left > 0);
        pop       <= pop_next;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, with an optional gap first; return at the edge that takes it.
    task automatic send_word(input logic [7:0] v, input logic l);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_in_value <= v;
        i_in_last  <= l;
        do @(posedge i_clk); while (full);
        run_codec(v, l);
        words_sent++;
    endtask

    // Send stream_buf as one stream, last set on its final word.
    task automatic send_stream();
        for (int k = 0; k < stream_buf.size(); k++)
            send_word(stream_buf[k], k == stream_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        stream_buf.delete();
        for (int k = 0; k < s.len(); k++)
            stream_buf.push_back(s[k]);
        send_stream();
    endtask

    // Stop offering and wait until every expected word has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge i_clk);
        // Give a word that emits nothing time to clear the pipeline.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Direction writes happen only with the codec idle; they also drop any partial group.
    task automatic write_direction(input logic d);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_dir = d;
        clear_stream();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encode from reset: full and short final groups, extreme bytes, partial group flush.
    task automatic test_encode_edges();
        stream_buf = '{8'h00, 8'hFF, 8'h80};
        send_stream();
        stream_buf = '{8'hFF};
        send_stream();
        stream_buf = '{8'h00, 8'h01};
        send_stream();
        stream_buf = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h01};
        send_stream();
        // One group with no last, then a partial group dropped by a direction write.
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h56, 1'b0);
        send_word(8'h9A, 1'b0);
        send_word(8'hBC, 1'b0);
        write_direction(DIR_ENCODE);
        send_word(8'hAA, 1'b1);
    endtask

    // Strict decode: padding forms and every kind of rejection.
    task automatic test_decode_rules();
        write_direction(DIR_DECODE);
        send_text("TQ==");          // two pad characters
        send_text("TWE=");          // one pad character
        stream_buf = '{8'h41, 8'hFF};
        send_stream();              // byte above 127, error on the last word
        send_text("=A");            // '=' first in the group
        send_text("A=");            // '=' second in the group
        send_text("AB=C");          // data after '='
        send_text("AB");            // length not a multiple of four
        send_text("TQ==A");         // word after a padded group
    endtask

    // Random byte streams of mixed lengths through the encoder.
    task automatic test_random_encode(input int n_items);
        int n;
        int sent;
        write_direction(DIR_ENCODE);
        sent = 0;
        while (sent < n_items) begin
            n = $urandom_range(1, 9);
            stream_buf.delete();
            repeat (n) stream_buf.push_back(8'($urandom_range(0, 255)));
            send_stream();
            sent += n;
        end
    endtask

    // Mostly well-formed encoded streams with random content; a quarter damaged.
    task automatic test_random_decode(input int n_items);
        logic [7:0]  raw[$];
        logic [23:0] g;
        int          nb;
        int          sent;
        int          pos;
        write_direction(DIR_DECODE);
        sent = 0;
        while (sent < n_items) begin
            raw.delete();
            stream_buf.delete();
            nb = $urandom_range(1, 7);
            repeat (nb) raw.push_back(8'($urandom_range(0, 255)));
            raw.push_back(8'h00);
            raw.push_back(8'h00);
            for (int k = 0; k < nb; k += 3) begin
                g = {raw[k], raw[k+1], raw[k+2]};
                stream_buf.push_back(sextet_char(g[23:18]));
                stream_buf.push_back(sextet_char(g[17:12]));
                stream_buf.push_back(k + 1 < nb ? sextet_char(g[11:6]) : PAD_CHAR);
                stream_buf.push_back(k + 2 < nb ? sextet_char(g[5:0]) : PAD_CHAR);
            end
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, stream_buf.size() - 1);
                case (t_flaw'($urandom_range(0, 3)))
                    FLAW_BYTE: begin
                        stream_buf[pos] = 8'($urandom_range(0, 255));
                    end
                    FLAW_SHORT: begin
                        while (stream_buf.size() > pos + 1)
                            void'(stream_buf.pop_back());
                    end
                    FLAW_TAIL: begin
                        repeat ($urandom_range(1, 3))
                            stream_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        stream_buf.insert(pos, PAD_CHAR);
                    end
                endcase
            end
            sent += stream_buf.size();
            send_stream();
        end
    endtask

    // Long output stall while bytes keep coming: the codec fills and raises full.
    task automatic test_output_stall();
        write_direction(DIR_ENCODE);
        hold_req <= 1'b1;
        do @(posedge i_clk); while (!hold_busy);
        hold_req <= 1'b0;
        stream_buf.delete();
        repeat (30) stream_buf.push_back(8'($urandom_range(0, 255)));
        send_stream();
        // Pause until the whole backlog has come out.
        wait_drained();
    endtask

    // Closing stretch with no gaps on either side, both directions.
    task automatic test_full_rate();
        idle_on <= 1'b0;
        test_random_encode(20);
        test_random_decode(30);
    endtask

    initial begin
        for (int i = 0; i < 256; i++)
            char_code[i] = -1;
        for (int i = 0; i < 64; i++)
            char_code[sextet_char(6'(i))] = i;
        cur_dir = DIR_ENCODE;
        clear_stream();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_edges();
        test_decode_rules();
        test_random_encode(70);
        test_random_decode(80);
        test_output_stall();
        test_full_rate();
        wait_drained();

        $display("Ran %0d input words and checked %0d result words (%0d decode rejections).",
                 words_sent, words_seen, error_words);
        $display("Covered encode padding, strict decode rules, direction changes and stalls.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/b64c_pkg.sv
rtl/b64c_front.sv
rtl/b64c_jobq.sv
rtl/b64c_back.sv
rtl/base64_codec_strict.sv
tb/sv/tb.sv
